// ===== hw/rtl/sorted_time_range_search_unit_defines.svh =====
// Assertion helpers for the time range search unit.
`ifndef SORTED_TIME_RANGE_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TIME_RANGE_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define STRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define STRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/stru_pkg.sv =====
package stru_pkg;

    localparam int unsigned STRU_DEPTH_DEF = 4096;
    localparam int unsigned TIME_W         = 64;
    localparam int unsigned IDX_W          = 13;
    localparam int unsigned ACT_W          = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_top_state;

    typedef enum logic [1:0] {
        SRCH_IDLE,
        SRCH_PROBE,
        SRCH_CMP
    } t_srch_state;

    // Launch of one bound search.
    typedef struct packed {
        logic start;
        logic inclusive;   // 1: upper bound (t <= key goes right), 0: lower bound
    } t_srch_req;

endpackage

// ===== hw/rtl/stru_mem.sv =====
module stru_mem #(
    parameter int unsigned DEPTH = stru_pkg::STRU_DEPTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [stru_pkg::TIME_W-1:0]               i_wr_data,
    input  logic                                      i_rd_en_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    output logic [stru_pkg::TIME_W-1:0]               o_rd_data_a,
    input  logic                                      i_rd_en_b,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic [stru_pkg::TIME_W-1:0]               o_rd_data_b
);
    import stru_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rd_a;
    logic [TIME_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en_a) begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_rd_en_b) begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== hw/rtl/stru_search.sv =====
module stru_search #(
    parameter int unsigned DEPTH = stru_pkg::STRU_DEPTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  stru_pkg::t_srch_req                       i_req,
    input  logic [stru_pkg::TIME_W-1:0]               i_key,
    input  logic [$clog2(DEPTH+1)-1:0]                i_count,
    output logic                                      o_rd_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_rd_addr,
    input  logic [stru_pkg::TIME_W-1:0]               i_rd_data,
    output logic                                      o_busy,
    output logic [$clog2(DEPTH+1)-1:0]                o_index
);
    import stru_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_srch_state       r_state;
    t_srch_state       n_state;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_mid;
    logic [TIME_W-1:0] r_key;
    logic              r_incl;
    logic [CW-1:0]     w_mid;
    logic              w_open;
    logic              w_go_right;

    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_open     = (r_lo < r_hi);
    assign w_go_right = r_incl ? (i_rd_data <= r_key) : (i_rd_data < r_key);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SRCH_IDLE:  if (i_req.start) n_state = SRCH_PROBE;
            SRCH_PROBE: n_state = w_open ? SRCH_CMP : SRCH_IDLE;
            SRCH_CMP:   n_state = SRCH_PROBE;
            default:    n_state = SRCH_IDLE;
        endcase
    end

    always_comb begin
        o_rd_en = 1'b0;
        o_busy  = 1'b1;
        unique case (r_state)
            SRCH_IDLE:  o_busy  = 1'b0;
            SRCH_PROBE: o_rd_en = w_open;
            SRCH_CMP:   o_rd_en = 1'b0;
            default:    o_busy  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SRCH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SRCH_IDLE: begin
                if (i_req.start) begin
                    r_lo   <= '0;
                    r_hi   <= i_count;
                    r_key  <= i_key;
                    r_incl <= i_req.inclusive;
                end
            end
            SRCH_PROBE: r_mid <= w_mid;
            SRCH_CMP: begin
                if (w_go_right) begin
                    r_lo <= r_mid + CW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            default: ;
        endcase
    end

    // while lo < hi, mid < hi <= DEPTH, so a probed address always fits
    assign o_rd_addr = w_mid[AW-1:0];
    assign o_index   = r_lo;

endmodule

// ===== hw/rtl/sorted_time_range_search_unit.sv =====
// Sorted time range search unit. Holds up to TABLE_DEPTH 64-bit timestamps,
// appended in non-decreasing order, in one synchronous RAM with one write
// port and two read ports. Each request gives exactly one response. A clear
// (action 0) empties the table; an append (action 1) writes the next entry,
// or sets append_dropped when the table is full. A
// window query (action 2) returns the lower bound of start_time and the
// upper bound of end_time, or zero for both when the table is empty or the
// start lies after the end. The two bounds are found by two binary search
// engines running side by side, one per RAM read port. Each probe puts out
// an address, then compares the registered read data that comes back. One
// request is in flight at a time; a finished response sits in an output
// register, and the next request is taken only once that register is empty
// or its response leaves in the same cycle. Stored words need no reset and
// there is no clearing pass: only entries below the fill count are ever
// read. Index outputs are 13 bits.
`include "sorted_time_range_search_unit_defines.svh"

module sorted_time_range_search_unit #(
    parameter int unsigned TABLE_DEPTH = stru_pkg::STRU_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [stru_pkg::ACT_W-1:0]    i_action,
    input  logic [stru_pkg::TIME_W-1:0]   i_entry_time,
    input  logic [stru_pkg::TIME_W-1:0]   i_start_time,
    input  logic [stru_pkg::TIME_W-1:0]   i_end_time,
    // response channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [stru_pkg::IDX_W-1:0]    o_first_index,
    output logic [stru_pkg::IDX_W-1:0]    o_end_index,
    output logic                          o_append_dropped
);
    import stru_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_top_state        r_state;
    t_top_state        n_state;
    logic [CW-1:0]     r_count;     // loaded entries
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_first;
    logic [IDX_W-1:0]  r_end;
    logic              r_drop;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_full;
    logic              w_query_go;  // query that needs a real search
    logic              w_load_imm;  // response ready at acceptance
    logic              w_load_srch; // response from the search engines
    t_srch_req         w_req_lo;
    t_srch_req         w_req_hi;

    logic              w_rd_en_lo;
    logic              w_rd_en_hi;
    logic [AW-1:0]     w_rd_addr_lo;
    logic [AW-1:0]     w_rd_addr_hi;
    logic [TIME_W-1:0] w_rd_data_lo;
    logic [TIME_W-1:0] w_rd_data_hi;
    logic              w_busy_lo;
    logic              w_busy_hi;
    logic [CW-1:0]     w_idx_lo;
    logic [CW-1:0]     w_idx_hi;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count >= CW'(TABLE_DEPTH));
    assign w_query_go = (i_action == ACT_QUERY) && (i_start_time <= i_end_time)
                        && (r_count != '0);

    // ---- control: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc && w_query_go) n_state = ST_SEARCH;
            ST_SEARCH: if (!w_busy_lo && !w_busy_hi && w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---- control: outputs ----
    always_comb begin
        o_in_stall  = 1'b1;
        w_in_acc    = 1'b0;
        w_load_imm  = 1'b0;
        w_load_srch = 1'b0;
        w_req_lo    = '0;
        w_req_hi    = '0;
        unique case (r_state)
            ST_IDLE: begin
                // a request is taken only when its response has room
                o_in_stall = !w_out_free;
                w_in_acc   = i_in_valid && w_out_free;
                w_load_imm = w_in_acc && !w_query_go;
                w_req_lo.start     = w_in_acc && w_query_go;
                w_req_lo.inclusive = 1'b0;
                w_req_hi.start     = w_in_acc && w_query_go;
                w_req_hi.inclusive = 1'b1;
            end
            ST_SEARCH: begin
                w_load_srch = !w_busy_lo && !w_busy_hi && w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                unique case (i_action)
                    ACT_CLEAR:  r_count <= '0;
                    ACT_APPEND: if (!w_full) r_count <= r_count + CW'(1);
                    default: ;
                endcase
            end
            if (w_load_imm || w_load_srch) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_load_imm) begin
            r_first <= '0;
            r_end   <= '0;
            r_drop  <= (i_action == ACT_APPEND) && w_full;
        end else if (w_load_srch) begin
            r_first <= IDX_W'(w_idx_lo);
            r_end   <= IDX_W'(w_idx_hi);
            r_drop  <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_index    = r_first;
    assign o_end_index      = r_end;
    assign o_append_dropped = r_drop;

    // ---- timestamp store ----
    stru_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (w_in_acc && (i_action == ACT_APPEND) && !w_full),
        .i_wr_addr   (r_count[AW-1:0]),
        .i_wr_data   (i_entry_time),
        .i_rd_en_a   (w_rd_en_lo),
        .i_rd_addr_a (w_rd_addr_lo),
        .o_rd_data_a (w_rd_data_lo),
        .i_rd_en_b   (w_rd_en_hi),
        .i_rd_addr_b (w_rd_addr_hi),
        .o_rd_data_b (w_rd_data_hi)
    );

    // lower bound of the window start
    stru_search #(
        .DEPTH(TABLE_DEPTH)
    ) u_search_lo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req_lo),
        .i_key     (i_start_time),
        .i_count   (r_count),
        .o_rd_en   (w_rd_en_lo),
        .o_rd_addr (w_rd_addr_lo),
        .i_rd_data (w_rd_data_lo),
        .o_busy    (w_busy_lo),
        .o_index   (w_idx_lo)
    );

    // upper bound of the window end
    stru_search #(
        .DEPTH(TABLE_DEPTH)
    ) u_search_hi (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req_hi),
        .i_key     (i_end_time),
        .i_count   (r_count),
        .o_rd_en   (w_rd_en_hi),
        .o_rd_addr (w_rd_addr_hi),
        .i_rd_data (w_rd_data_hi),
        .o_busy    (w_busy_hi),
        .o_index   (w_idx_hi)
    );

    // ---- checks ----
    `STRU_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH), "fill count past table depth")
    `STRU_ASSERT_NEXT(a_count_frozen, i_clk, i_rst_n, r_state == ST_SEARCH, $stable(r_count), "fill count moved during a search")
    `STRU_ASSERT_NOW(a_bound_range, i_clk, i_rst_n, w_load_srch, (w_idx_lo <= r_count) && (w_idx_hi <= r_count), "search bound past fill count")
    `STRU_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, w_in_acc && (i_action == ACT_APPEND) && w_full, (r_count == $past(r_count)) && o_append_dropped, "append to full table not dropped")

endmodule

// ===== dv/sorted_time_range_search_unit_tb.sv =====
`timescale 1ns / 100ps

// Block-level bench for the time range search unit.
// The sender drives clear / append / window requests, and a tracker mirrors the
// table to predict each response. The receiver checks responses in order.
// Both sides idle at random, with one quiet stretch and one long receiver hold-off.
module sorted_time_range_search_unit_tb;
    import stru_pkg::*;

    localparam int unsigned       DEPTH        = STRU_DEPTH_DEF;
    localparam logic [ACT_W-1:0]  ACT_UNUSED   = 2'd3;    // no-op action code
    localparam logic [TIME_W-1:0] T_MAX        = '1;
    localparam int unsigned       RANDOM_ITEMS = 630;
    localparam int unsigned       DRAIN_CYCLES = 64;      // idle margin after the last response is checked
    localparam int unsigned       MAX_REPORTS  = 10;
    localparam int unsigned       HOLD_CYCLES  = 300;     // receiver hold-off length
    localparam int unsigned       HOLD_AFTER   = 150;     // responses before the hold-off

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] end_index;
        logic             append_dropped;
    } t_window_result;

    // Mirror of the timestamp table plus the responses still owed by the block.
    class window_bound_tracker;
        logic [TIME_W-1:0] times [DEPTH];
        logic [IDX_W-1:0]  loaded;
        t_window_result    due[$];
        int unsigned       answered;
        int unsigned       faults;

        function new();
            loaded   = '0;
            answered = 0;
            faults   = 0;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        // Lower bound (inclusive = 0) or upper bound (inclusive = 1) over loaded entries.
        function logic [IDX_W-1:0] bound_index(logic [TIME_W-1:0] key, bit inclusive);
            logic [IDX_W-1:0] lo;
            logic [IDX_W-1:0] hi;
            logic [IDX_W-1:0] mid;
            logic             go_right;
            lo = '0;
            hi = loaded;
            while (lo < hi) begin
                mid      = lo + ((hi - lo) >> 1);
                go_right = inclusive ? (times[mid] <= key) : (times[mid] < key);
                if (go_right) begin
                    lo = mid + 1'b1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void take_request(logic [ACT_W-1:0] act, logic [TIME_W-1:0] t_entry,
                                   logic [TIME_W-1:0] t_start, logic [TIME_W-1:0] t_end);
            t_window_result r;
            r = '0;
            case (act)
                ACT_CLEAR: begin
                    loaded = '0;
                end
                ACT_APPEND: begin
                    if (loaded >= DEPTH) begin
                        r.append_dropped = 1'b1;
                    end else begin
                        times[loaded] = t_entry;
                        loaded++;
                    end
                end
                ACT_QUERY: begin
                    if (t_start <= t_end && loaded != 0) begin
                        r.first_index = bound_index(t_start, 1'b0);
                        r.end_index   = bound_index(t_end, 1'b1);
                    end
                end
                default: ;
            endcase
            due.push_back(r);
        endfunction

        function void match_response(logic [IDX_W-1:0] fi, logic [IDX_W-1:0] ei, logic dr);
            t_window_result want;
            if (due.size() == 0) begin
                note_fault($sformatf("unexpected response: first_index %0d end_index %0d drop %0b",
                                     fi, ei, dr));
                return;
            end
            want = due.pop_front();
            if (want.first_index !== fi || want.end_index !== ei
                    || want.append_dropped !== dr) begin
                note_fault($sformatf({"mismatch on response %0d (exp/act): first_index %0d/%0d",
                                      " end_index %0d/%0d append_dropped %0b/%0b"},
                                     answered, want.first_index, fi, want.end_index, ei,
                                     want.append_dropped, dr));
            end
            answered++;
        endfunction

        function void flag_leftovers();
            if (due.size() != 0) begin
                note_fault($sformatf("%0d responses never arrived", due.size()));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [ACT_W-1:0]     i_action     = '0;
    logic [TIME_W-1:0]    i_entry_time = '0;
    logic [TIME_W-1:0]    i_start_time = '0;
    logic [TIME_W-1:0]    i_end_time   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [IDX_W-1:0]     o_first_index;
    logic [IDX_W-1:0]     o_end_index;
    logic                 o_append_dropped;

    window_bound_tracker tracker = new();
    int unsigned         items_sent = 0;
    bit                  calm = 1'b0;       // both sides stop idling while set

    sorted_time_range_search_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_entry_time     (i_entry_time),
        .i_start_time     (i_start_time),
        .i_end_time       (i_end_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_first_index    (o_first_index),
        .o_end_index      (o_end_index),
        .o_append_dropped (o_append_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generous watchdog limit for the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("[sorted_time_range_search_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Value helpers
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] sum;
        sum = a + b;
        return (sum < a) ? T_MAX : sum;
    endfunction

    // Idle length before a request: about 16% per cycle, none while calm.
    function automatic int unsigned rest_cycles();
        int unsigned n;
        n = 0;
        if (!calm) begin
            while ($urandom_range(99) < 16) n++;
        end
        return n;
    endfunction

    // Gap between consecutive sorted timestamps: duplicates are common.
    function automatic logic [TIME_W-1:0] time_step();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3) return '0;
        if (r < 8) return $urandom_range(1, 16);
        if (r == 8) return $urandom;
        return rand64() >> $urandom_range(1, 63);
    endfunction

    function automatic logic [TIME_W-1:0] pick_base();
        int unsigned r;
        r = $urandom_range(5);
        if (r == 0) return '0;
        if (r == 1) return T_MAX - $urandom_range(0, 64);   // runs into saturation
        return rand64() >> $urandom_range(0, 8);
    endfunction

    // Search key: mostly on or next to a loaded entry, sometimes an extreme or noise.
    function automatic logic [TIME_W-1:0] pick_key();
        int unsigned       r;
        int unsigned       idx;
        logic [TIME_W-1:0] v;
        r = $urandom_range(9);
        if (tracker.loaded == 0 || r >= 8) return rand64();
        if (r == 7) return $urandom_range(1) ? T_MAX : '0;
        idx = $urandom_range(0, tracker.loaded - 1);
        v   = tracker.times[idx];
        if (r < 3) return v;
        if (r < 5) return (v == 0) ? v : v - 1'b1;
        return sat_add(v, 1);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Called at the edge where the previous request was taken,
    // so valid gets exactly one assignment in that step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] t_entry,
                                input logic [TIME_W-1:0] t_start,
                                input logic [TIME_W-1:0] t_end);
        int unsigned gap;
        gap = rest_cycles();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_entry_time <= t_entry;
        i_start_time <= t_start;
        i_end_time   <= t_end;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_request(act, t_entry, t_start, t_end);
        items_sent++;
    endtask

    task automatic send_window(input logic [TIME_W-1:0] t_start, input logic [TIME_W-1:0] t_end);
        send_request(ACT_QUERY, rand64(), t_start, t_end);
    endtask

    task automatic send_append(input logic [TIME_W-1:0] t_entry);
        send_request(ACT_APPEND, t_entry, rand64(), rand64());
    endtask

    // ------------------------------------------------------------------
    // Response side: check, then pick the stall for the next cycle.
    // One long hold-off lets the block back up into the request channel.
    // ------------------------------------------------------------------
    initial begin : response_side
        int unsigned hold_left;
        bit          held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                tracker.match_response(o_first_index, o_end_index, o_append_dropped);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!held_once && tracker.answered >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed cases: empty table, extremes, duplicates, reversed window,
    // out-of-order append, unused action, clear.
    // ------------------------------------------------------------------
    task automatic run_directed();
        send_window('0, T_MAX);                                  // empty table
        send_request(ACT_UNUSED, rand64(), rand64(), rand64());
        send_append('0);
        send_append('0);                                         // duplicate
        send_append(64'h0123_4567_89AB_CDEF);
        send_append(T_MAX);
        send_window('0, '0);
        send_window('0, T_MAX);
        send_window(64'd1, T_MAX - 1'b1);
        send_window(T_MAX, T_MAX);
        send_window(T_MAX, '0);                                  // reversed
        send_window(64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF);
        send_append(64'd5);                                      // out of order
        send_window('0, T_MAX);
        send_window(64'd5, 64'd5);
        send_request(ACT_CLEAR, rand64(), rand64(), rand64());
        send_window('0, T_MAX);                                  // cleared table
        send_append(T_MAX);
        send_window(T_MAX, T_MAX);
        send_request(ACT_CLEAR, rand64(), rand64(), rand64());
    endtask

    // One random episode: usually a clear, a sorted run of appends with the odd
    // stray value, then searches around the loaded values plus some noise.
    logic [TIME_W-1:0] next_time = '0;

    task automatic run_episode();
        int unsigned       n_app;
        int unsigned       n_q;
        int unsigned       i;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        logic [TIME_W-1:0] tmp;
        if ($urandom_range(99) < 60 || tracker.loaded > 1000) begin
            send_request(ACT_CLEAR, rand64(), rand64(), rand64());
            next_time = pick_base();
        end
        n_app = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
        for (i = 0; i < n_app; i++) begin
            if ($urandom_range(49) == 0) begin
                send_append(rand64());                           // stray, out of order
            end else begin
                next_time = sat_add(next_time, time_step());
                send_append(next_time);
            end
            if ($urandom_range(39) == 0) begin
                send_window(pick_key(), pick_key());             // mid-load search
            end
        end
        n_q = $urandom_range(1, 8);
        for (i = 0; i < n_q; i++) begin
            s = pick_key();
            e = pick_key();
            if (s > e && $urandom_range(9) != 0) begin
                tmp = s;
                s   = e;
                e   = tmp;
            end
            send_window(s, e);
        end
        if ($urandom_range(9) == 0) begin
            send_request(ACT_UNUSED, rand64(), rand64(), rand64());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_base;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            // quiet stretch: no idling on either side
            calm = (items_sent - random_base >= 250) && (items_sent - random_base < 360);
            run_episode();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;
        while (tracker.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.flag_leftovers();
        if (tracker.faults == 0) begin
            $display("[sorted_time_range_search_unit] OK");
        end else begin
            $display("[sorted_time_range_search_unit] ERROR");
        end
        $finish;
    end

endmodule
